// ----- rtl/rrts_pkg.sv -----
// Shared types and constants for the round robin task scheduler.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package rrts_pkg;

    localparam int SLOT_COUNT       = 8;
    localparam int SLOT_STACK_BYTES = 1024;
    localparam int SLOT_W           = $clog2(SLOT_COUNT);
    localparam int DATA_W           = 32;
    localparam int OP_W             = 2;
    localparam int SLOT_OUT_W       = 3;

    typedef enum logic [OP_W-1:0] {
        OP_YIELD  = 2'd0,
        OP_CLOSE  = 2'd1,
        OP_CREATE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_FREE      = 3'd0,
        ST_NEW       = 3'd1,
        ST_RUNNING   = 3'd2,
        ST_HALTED    = 3'd3,
        ST_COMPLETED = 3'd4
    } slot_state_t;

    typedef logic [SLOT_W-1:0] slot_idx_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic close_mark;
        logic scan_init_create;
        logic scan_init_switch;
        logic scan_step;
        logic claim;
        logic found;
        logic load;
        logic no_ready;
        logic load_out;
    } rrts_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            hit_free;
        logic            hit_ready;
        logic            scan_last;
        logic            out_free;
    } rrts_status_t;

    function automatic slot_idx_t slot_inc(slot_idx_t s);
        slot_inc = (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rrts_ctrl.sv -----
// Sequencer for the scheduler: accept, slot scan, start of the chosen slot, result hand-off.
// Depends on rrts_pkg for the command and status structs and opcodes.
`default_nettype none

module rrts_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire rrts_pkg::rrts_status_t st,
    output rrts_pkg::rrts_cmd_t        cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLOSE,
        S_SCAN_CREATE,
        S_SCAN_READY,
        S_LOAD,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    unique case (st.op)
                        rrts_pkg::OP_CREATE: begin
                            cmd.scan_init_create = 1'b1;
                            state_next           = S_SCAN_CREATE;
                        end
                        rrts_pkg::OP_CLOSE: begin
                            state_next = S_CLOSE;
                        end
                        rrts_pkg::OP_YIELD: begin
                            cmd.scan_init_switch = 1'b1;
                            state_next           = S_SCAN_READY;
                        end
                        default: begin
                            // unused opcode: report the current slot only
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CLOSE: begin
                cmd.close_mark       = 1'b1;
                cmd.scan_init_switch = 1'b1;
                state_next           = S_SCAN_READY;
            end
            S_SCAN_CREATE: begin
                priority if (st.hit_free) begin
                    cmd.claim  = 1'b1;
                    state_next = S_DONE;
                end else if (st.scan_last) begin
                    state_next = S_DONE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_SCAN_READY: begin
                priority if (st.hit_ready) begin
                    cmd.found  = 1'b1;
                    state_next = S_LOAD;
                end else if (st.scan_last) begin
                    cmd.no_ready = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_LOAD: begin
                cmd.load   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (st.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/rrts_dp.sv -----
// Scheduler datapath: slot states, saved pointer and entry memories, scan index,
// stack offset, result and output registers. Depends on rrts_pkg.
`default_nettype none

module rrts_dp (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_we,
    input  wire logic [rrts_pkg::DATA_W-1:0]          cfg_wdata,
    input  wire logic [rrts_pkg::OP_W-1:0]            s_opcode,
    input  wire logic [rrts_pkg::DATA_W-1:0]          s_entry_address,
    input  wire logic [rrts_pkg::DATA_W-1:0]          s_stack_pointer,
    input  wire logic                                 m_ready,
    output logic                                      m_valid,
    output logic [rrts_pkg::SLOT_OUT_W-1:0]           m_running_slot,
    output logic                                      m_switched,
    output logic                                      m_fresh_start,
    output logic [rrts_pkg::DATA_W-1:0]               m_resume_pointer,
    output logic [rrts_pkg::DATA_W-1:0]               m_start_address,
    output logic                                      m_create_ok,
    output logic [rrts_pkg::SLOT_OUT_W-1:0]           m_created_slot,
    output logic                                      m_none_ready,
    input  wire rrts_pkg::rrts_cmd_t                  cmd,
    output rrts_pkg::rrts_status_t                    st
);

    localparam int DW = rrts_pkg::DATA_W;
    localparam int OW = rrts_pkg::SLOT_OUT_W;
    localparam int N  = rrts_pkg::SLOT_COUNT;

    // control state
    logic [DW-1:0]          stack_top_reg;
    rrts_pkg::slot_state_t  slot_state_reg [N];
    rrts_pkg::slot_idx_t    cur_reg;
    rrts_pkg::slot_idx_t    scan_idx_reg;
    rrts_pkg::slot_idx_t    scan_cnt_reg;
    logic                   m_valid_reg;

    // payload
    logic [DW-1:0]          saved_mem [N];
    logic [DW-1:0]          entry_mem [N];
    logic [DW-1:0]          saved_rd_reg;
    logic [DW-1:0]          entry_rd_reg;
    logic [DW-1:0]          entry_in_reg;
    logic [DW-1:0]          sp_in_reg;
    logic [DW-1:0]          offset_reg;
    rrts_pkg::slot_idx_t    pick_reg;
    logic                   pick_halted_reg;

    logic                   res_switched_reg;
    logic                   res_fresh_reg;
    logic [DW-1:0]          res_resume_reg;
    logic [DW-1:0]          res_start_reg;
    logic                   res_create_ok_reg;
    rrts_pkg::slot_idx_t    res_created_reg;
    logic                   res_none_ready_reg;

    logic [OW-1:0]          m_running_slot_reg;
    logic                   m_switched_reg;
    logic                   m_fresh_start_reg;
    logic [DW-1:0]          m_resume_pointer_reg;
    logic [DW-1:0]          m_start_address_reg;
    logic                   m_create_ok_reg;
    logic [OW-1:0]          m_created_slot_reg;
    logic                   m_none_ready_reg;

    rrts_pkg::slot_state_t  scan_state;
    rrts_pkg::slot_state_t  cur_state;
    logic [DW-1:0]          offset_next;

    assign scan_state = slot_state_reg[scan_idx_reg];
    assign cur_state  = slot_state_reg[cur_reg];

    // fresh stack of slot s sits (s+1) slot stacks below the top
    assign offset_next = (DW'(scan_idx_reg) + DW'(1)) * DW'(rrts_pkg::SLOT_STACK_BYTES);

    assign st.op        = s_opcode;
    assign st.hit_free  = (scan_state == rrts_pkg::ST_FREE) ||
                          (scan_state == rrts_pkg::ST_COMPLETED);
    assign st.hit_ready = (scan_state == rrts_pkg::ST_NEW) ||
                          (scan_state == rrts_pkg::ST_HALTED);
    assign st.scan_last = (scan_cnt_reg == rrts_pkg::SLOT_W'(N - 1));
    assign st.out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_top_reg <= '0;
            cur_reg       <= '0;
            scan_idx_reg  <= '0;
            scan_cnt_reg  <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < N; i++) begin
                slot_state_reg[i] <= rrts_pkg::ST_FREE;
            end
        end else begin
            if (cfg_we) begin
                stack_top_reg <= cfg_wdata;
            end
            if (cmd.scan_init_create) begin
                scan_idx_reg <= '0;
                scan_cnt_reg <= '0;
            end else if (cmd.scan_init_switch) begin
                // visit the current slot last
                scan_idx_reg <= rrts_pkg::slot_inc(cur_reg);
                scan_cnt_reg <= '0;
            end else if (cmd.scan_step) begin
                scan_idx_reg <= rrts_pkg::slot_inc(scan_idx_reg);
                scan_cnt_reg <= scan_cnt_reg + rrts_pkg::SLOT_W'(1);
            end
            if (cmd.close_mark) begin
                slot_state_reg[cur_reg] <= rrts_pkg::ST_COMPLETED;
            end
            if (cmd.claim) begin
                slot_state_reg[scan_idx_reg] <= rrts_pkg::ST_NEW;
            end
            if (cmd.found && cur_state == rrts_pkg::ST_RUNNING) begin
                slot_state_reg[cur_reg] <= rrts_pkg::ST_HALTED;
            end
            if (cmd.load) begin
                slot_state_reg[pick_reg] <= rrts_pkg::ST_RUNNING;
                cur_reg                  <= pick_reg;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // memories: one write and one registered read per cycle each
    always_ff @(posedge aclk) begin
        if (cmd.claim) begin
            entry_mem[scan_idx_reg] <= entry_in_reg;
        end
        if (cmd.found && cur_state == rrts_pkg::ST_RUNNING) begin
            saved_mem[cur_reg] <= sp_in_reg;
        end
        if (cmd.found) begin
            saved_rd_reg <= saved_mem[scan_idx_reg];
            entry_rd_reg <= entry_mem[scan_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            entry_in_reg       <= s_entry_address;
            sp_in_reg          <= s_stack_pointer;
            res_switched_reg   <= 1'b0;
            res_fresh_reg      <= 1'b0;
            res_resume_reg     <= '0;
            res_start_reg      <= '0;
            res_create_ok_reg  <= 1'b0;
            res_created_reg    <= '0;
            res_none_ready_reg <= 1'b0;
        end
        if (cmd.claim) begin
            res_create_ok_reg <= 1'b1;
            res_created_reg   <= scan_idx_reg;
        end
        if (cmd.no_ready) begin
            res_none_ready_reg <= 1'b1;
        end
        if (cmd.found) begin
            pick_reg        <= scan_idx_reg;
            pick_halted_reg <= (scan_state == rrts_pkg::ST_HALTED);
            offset_reg      <= offset_next;
        end
        if (cmd.load) begin
            res_switched_reg <= 1'b1;
            res_fresh_reg    <= !pick_halted_reg;
            res_resume_reg   <= pick_halted_reg ? saved_rd_reg : stack_top_reg - offset_reg;
            res_start_reg    <= pick_halted_reg ? '0 : entry_rd_reg;
        end
        if (cmd.load_out) begin
            m_running_slot_reg   <= OW'(cur_reg);
            m_switched_reg       <= res_switched_reg;
            m_fresh_start_reg    <= res_fresh_reg;
            m_resume_pointer_reg <= res_resume_reg;
            m_start_address_reg  <= res_start_reg;
            m_create_ok_reg      <= res_create_ok_reg;
            m_created_slot_reg   <= OW'(res_created_reg);
            m_none_ready_reg     <= res_none_ready_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_running_slot   = m_running_slot_reg;
    assign m_switched       = m_switched_reg;
    assign m_fresh_start    = m_fresh_start_reg;
    assign m_resume_pointer = m_resume_pointer_reg;
    assign m_start_address  = m_start_address_reg;
    assign m_create_ok      = m_create_ok_reg;
    assign m_created_slot   = m_created_slot_reg;
    assign m_none_ready     = m_none_ready_reg;

endmodule

`default_nettype wire

// ----- rtl/round_robin_task_scheduler.sv -----
// Top level of the round robin task scheduler: sequencer plus datapath.
// Depends on rrts_pkg, rrts_ctrl and rrts_dp.
//
// One event at a time. A create scans slots from 0, one slot per clock. A yield
// scans from the slot after the current one, one slot per clock, then reads the
// chosen slot's saved pointer and entry address into registers and starts it;
// a close first marks the current slot completed. An unused opcode goes
// straight to the result. The next event is taken as soon as the result sits in
// the output register, even while it waits for m_ready. stack_top may be
// written only while no event is in flight.
`default_nettype none

module round_robin_task_scheduler (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [rrts_pkg::DATA_W-1:0]        cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [rrts_pkg::OP_W-1:0]          s_opcode,
    input  wire logic [rrts_pkg::DATA_W-1:0]        s_entry_address,
    input  wire logic [rrts_pkg::DATA_W-1:0]        s_stack_pointer,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [rrts_pkg::SLOT_OUT_W-1:0]         m_running_slot,
    output logic                                    m_switched,
    output logic                                    m_fresh_start,
    output logic [rrts_pkg::DATA_W-1:0]             m_resume_pointer,
    output logic [rrts_pkg::DATA_W-1:0]             m_start_address,
    output logic                                    m_create_ok,
    output logic [rrts_pkg::SLOT_OUT_W-1:0]         m_created_slot,
    output logic                                    m_none_ready
);

    rrts_pkg::rrts_cmd_t    cmd;
    rrts_pkg::rrts_status_t st;

    rrts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    rrts_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_opcode         (s_opcode),
        .s_entry_address  (s_entry_address),
        .s_stack_pointer  (s_stack_pointer),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_running_slot   (m_running_slot),
        .m_switched       (m_switched),
        .m_fresh_start    (m_fresh_start),
        .m_resume_pointer (m_resume_pointer),
        .m_start_address  (m_start_address),
        .m_create_ok      (m_create_ok),
        .m_created_slot   (m_created_slot),
        .m_none_ready     (m_none_ready),
        .cmd              (cmd),
        .st               (st)
    );

endmodule

`default_nettype wire

// ----- rtl/rrts_checker.sv -----
// Port-level checks on the scheduler's result channel, bound to the top level.
// Depends on rrts_pkg for field widths.
`default_nettype none

module rrts_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire logic [rrts_pkg::SLOT_OUT_W-1:0]    m_running_slot,
    input wire logic                               m_switched,
    input wire logic                               m_fresh_start,
    input wire logic [rrts_pkg::DATA_W-1:0]        m_resume_pointer,
    input wire logic [rrts_pkg::DATA_W-1:0]        m_start_address,
    input wire logic                               m_create_ok,
    input wire logic                               m_none_ready
);

    // a stalled transaction holds its running slot and resume pointer
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_running_slot) && $stable(m_resume_pointer))
        else $error("result changed while stalled");

    a_switch_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_switched && m_none_ready) && !(m_switched && m_create_ok))
        else $error("switch reported alongside create or none_ready");

    a_no_switch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_switched |->
            !m_fresh_start && m_resume_pointer == '0 && m_start_address == '0)
        else $error("start fields set without a switch");

    a_resume_zero_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_switched && !m_fresh_start |-> m_start_address == '0)
        else $error("start address set on a resume");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_running_slot   (m_running_slot),
    .m_switched       (m_switched),
    .m_fresh_start    (m_fresh_start),
    .m_resume_pointer (m_resume_pointer),
    .m_start_address  (m_start_address),
    .m_create_ok      (m_create_ok),
    .m_none_ready     (m_none_ready)
);

`default_nettype wire

// ----- tb/tb_round_robin_task_scheduler.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for round_robin_task_scheduler: directed and random events,
// random stalls on both channels, checked against a scheduler model held in a class.
// Depends on rrts_pkg and the scheduler RTL; reads no files.

module tb_round_robin_task_scheduler;

    localparam int CLK_PERIOD    = 8;
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 300;
    localparam int REPORT_MAX    = 10;
    localparam logic [rrts_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [rrts_pkg::SLOT_OUT_W-1:0] running_slot;
        logic                            switched;
        logic                            fresh_start;
        logic [rrts_pkg::DATA_W-1:0]     resume_pointer;
        logic [rrts_pkg::DATA_W-1:0]     start_address;
        logic                            create_ok;
        logic [rrts_pkg::SLOT_OUT_W-1:0] created_slot;
        logic                            none_ready;
    } sched_outcome_t;

    class sched_scoreboard;
        rrts_pkg::slot_state_t       slot_st [rrts_pkg::SLOT_COUNT];
        logic [rrts_pkg::DATA_W-1:0] saved_sp [rrts_pkg::SLOT_COUNT];
        logic [rrts_pkg::DATA_W-1:0] entry_of [rrts_pkg::SLOT_COUNT];
        int unsigned                 cur;
        logic [rrts_pkg::DATA_W-1:0] stack_top;
        sched_outcome_t              pending_outcomes [$];
        int unsigned                 mismatches;

        function new();
            foreach (slot_st[s]) begin
                slot_st[s]  = rrts_pkg::ST_FREE;
                saved_sp[s] = '0;
                entry_of[s] = '0;
            end
            cur        = 0;
            stack_top  = '0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return pending_outcomes.size();
        endfunction

        // Accepted input transaction: advance the model and queue the outcome.
        function void note_event(logic [rrts_pkg::OP_W-1:0] op,
                                 logic [rrts_pkg::DATA_W-1:0] entry,
                                 logic [rrts_pkg::DATA_W-1:0] sp);
            sched_outcome_t o;
            int unsigned    cand;
            int unsigned    pick;
            bit             found;
            o = '0;
            if (op == rrts_pkg::OP_CREATE) begin
                found = 0;
                for (int s = 0; s < rrts_pkg::SLOT_COUNT; s++) begin
                    if (!found && (slot_st[s] == rrts_pkg::ST_FREE ||
                                   slot_st[s] == rrts_pkg::ST_COMPLETED)) begin
                        slot_st[s]     = rrts_pkg::ST_NEW;
                        entry_of[s]    = entry;
                        o.create_ok    = 1'b1;
                        o.created_slot = rrts_pkg::SLOT_OUT_W'(s);
                        found          = 1;
                    end
                end
            end else if (op == rrts_pkg::OP_CLOSE || op == rrts_pkg::OP_YIELD) begin
                if (op == rrts_pkg::OP_CLOSE)
                    slot_st[cur] = rrts_pkg::ST_COMPLETED;
                // round robin from the next slot; the current one comes last
                found = 0;
                pick  = 0;
                for (int k = 1; k <= rrts_pkg::SLOT_COUNT; k++) begin
                    cand = (cur + k) % rrts_pkg::SLOT_COUNT;
                    if (!found && (slot_st[cand] == rrts_pkg::ST_NEW ||
                                   slot_st[cand] == rrts_pkg::ST_HALTED)) begin
                        pick  = cand;
                        found = 1;
                    end
                end
                if (!found) begin
                    o.none_ready = 1'b1;
                end else begin
                    if (slot_st[cur] == rrts_pkg::ST_RUNNING) begin
                        saved_sp[cur] = sp;
                        slot_st[cur]  = rrts_pkg::ST_HALTED;
                    end
                    cur        = pick;
                    o.switched = 1'b1;
                    if (slot_st[pick] == rrts_pkg::ST_HALTED) begin
                        o.resume_pointer = saved_sp[pick];
                    end else begin
                        o.fresh_start    = 1'b1;
                        o.resume_pointer = stack_top -
                            32'((pick + 1) * rrts_pkg::SLOT_STACK_BYTES);
                        o.start_address  = entry_of[pick];
                    end
                    slot_st[pick] = rrts_pkg::ST_RUNNING;
                end
            end
            o.running_slot = rrts_pkg::SLOT_OUT_W'(cur);
            pending_outcomes.push_back(o);
        endfunction

        function void compare_field(string field, logic [rrts_pkg::DATA_W-1:0] want,
                                    logic [rrts_pkg::DATA_W-1:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
            end
        endfunction

        function void check_result(sched_outcome_t got);
            sched_outcome_t want;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result transaction with nothing outstanding, slot %0d",
                             $realtime, got.running_slot);
                return;
            end
            want = pending_outcomes.pop_front();
            compare_field("running_slot",   want.running_slot,   got.running_slot);
            compare_field("switched",       want.switched,       got.switched);
            compare_field("fresh_start",    want.fresh_start,    got.fresh_start);
            compare_field("resume_pointer", want.resume_pointer, got.resume_pointer);
            compare_field("start_address",  want.start_address,  got.start_address);
            compare_field("create_ok",      want.create_ok,      got.create_ok);
            compare_field("created_slot",   want.created_slot,   got.created_slot);
            compare_field("none_ready",     want.none_ready,     got.none_ready);
        endfunction
    endclass

    logic                            aclk            = 1'b0;
    logic                            aresetn         = 1'b0;
    logic                            cfg_we          = 1'b0;
    logic [rrts_pkg::DATA_W-1:0]     cfg_wdata       = '0;
    logic                            s_valid         = 1'b0;
    logic                            s_ready;
    logic [rrts_pkg::OP_W-1:0]       s_opcode        = rrts_pkg::OP_YIELD;
    logic [rrts_pkg::DATA_W-1:0]     s_entry_address = '0;
    logic [rrts_pkg::DATA_W-1:0]     s_stack_pointer = '0;
    logic                            m_valid;
    logic                            m_ready         = 1'b0;
    logic [rrts_pkg::SLOT_OUT_W-1:0] m_running_slot;
    logic                            m_switched;
    logic                            m_fresh_start;
    logic [rrts_pkg::DATA_W-1:0]     m_resume_pointer;
    logic [rrts_pkg::DATA_W-1:0]     m_start_address;
    logic                            m_create_ok;
    logic [rrts_pkg::SLOT_OUT_W-1:0] m_created_slot;
    logic                            m_none_ready;

    sched_outcome_t  observed;
    sched_scoreboard sb;
    bit              quiet        = 1'b0;
    int              hold_request = 0;

    assign observed = {m_running_slot, m_switched, m_fresh_start, m_resume_pointer,
                       m_start_address, m_create_ok, m_created_slot, m_none_ready};

    round_robin_task_scheduler dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_entry_address  (s_entry_address),
        .s_stack_pointer  (s_stack_pointer),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_running_slot   (m_running_slot),
        .m_switched       (m_switched),
        .m_fresh_start    (m_fresh_start),
        .m_resume_pointer (m_resume_pointer),
        .m_start_address  (m_start_address),
        .m_create_ok      (m_create_ok),
        .m_created_slot   (m_created_slot),
        .m_none_ready     (m_none_ready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // mostly short gaps, a few long ones; none at all in a quiet phase
    function automatic int idle_cycles();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [rrts_pkg::DATA_W-1:0] rand_word();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom();
    endfunction

    task automatic send_event(logic [rrts_pkg::OP_W-1:0] op,
                              logic [rrts_pkg::DATA_W-1:0] entry,
                              logic [rrts_pkg::DATA_W-1:0] sp);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_entry_address <= entry;
        s_stack_pointer <= sp;
        do @(posedge aclk); while (!s_ready);
        sb.note_event(op, entry, sp);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_stack_top(logic [rrts_pkg::DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        sb.stack_top = value;
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(observed);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left == 0)
                stall_left = idle_cycles();
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb_round_robin_task_scheduler failed");
        $finish;
    end

    initial begin : stimulus
        logic [rrts_pkg::DATA_W-1:0] top_values [4];
        logic [rrts_pkg::OP_W-1:0]   op;
        int                          counted;
        int                          r;
        sb = new();
        top_values[0] = 32'hFFFF_FFFF;
        top_values[1] = 32'h2000_5000;
        top_values[2] = $urandom();
        top_values[3] = 32'h0000_0000;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, unused code, in-place start, full table, wrap-around
        send_event(rrts_pkg::OP_YIELD,  32'h0,         32'h0);
        send_event(OP_UNUSED,           32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(rrts_pkg::OP_CREATE, 32'hFFFF_FFFF, 32'h0);
        send_event(rrts_pkg::OP_YIELD,  32'h0,         32'hFFFF_FFFF);
        send_event(rrts_pkg::OP_CLOSE,  32'h0,         32'h1234_5678);
        for (int s = 0; s < rrts_pkg::SLOT_COUNT; s++)
            send_event(rrts_pkg::OP_CREATE,
                       (s == 0) ? 32'h0 : (s == 1) ? 32'hFFFF_FFFF : $urandom(),
                       $urandom());
        send_event(rrts_pkg::OP_CREATE, 32'hDEAD_BEEF, 32'h0);   // no slot left
        send_event(rrts_pkg::OP_YIELD,  32'h0, 32'hFFFF_FFFF);
        send_event(rrts_pkg::OP_YIELD,  32'h0, 32'h0);
        for (int k = 0; k < 5; k++)
            send_event(rrts_pkg::OP_YIELD, $urandom(), $urandom());
        send_event(rrts_pkg::OP_CLOSE,  32'h0, $urandom());
        send_event(rrts_pkg::OP_CLOSE,  32'h0, $urandom());
        send_event(OP_UNUSED,           32'h0, 32'h0);
        send_event(rrts_pkg::OP_YIELD,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_for_results();

        for (int p = 0; p < 4; p++) begin
            set_stack_top(top_values[p]);
            quiet   = (p == 1);
            counted = 0;
            while (counted < 100) begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    op = OP_UNUSED;
                else if (r < 35)
                    op = rrts_pkg::OP_CREATE;
                else if (r < 75)
                    op = rrts_pkg::OP_YIELD;
                else
                    op = rrts_pkg::OP_CLOSE;
                send_event(op, rand_word(), rand_word());
                if (op != OP_UNUSED)
                    counted++;
                // sink holds off while events keep coming, so the block backs up
                if (p == 2 && counted == 20 && op != OP_UNUSED)
                    hold_request = LONG_HOLD;
                if (p == 3 && counted == 50 && op != OP_UNUSED)
                    wait_for_results();
            end
            wait_for_results();
        end

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tb_round_robin_task_scheduler passed");
        else
            $display("tb_round_robin_task_scheduler failed");
        $finish;
    end

endmodule
